// ===== hw/rtl/first_fit_heap_allocator_defines.svh =====
// Assertion macros for the heap allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
// Assert an implication on the next cycle.
`define FFH_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
// Assert an implication in the same cycle.
`define FFH_ASSERT_NOW(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/ffh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffh_pkg
// Constants and types shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffh_pkg;
  localparam int unsigned HeapBytes   = 4096;
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned AlignBytes  = 8;
  localparam int unsigned HeapMin     = 64;
  localparam int unsigned Depth       = HeapBytes / AlignBytes;
  localparam int unsigned IdxW        = $clog2(Depth);
  localparam int unsigned LinkW       = IdxW + 1;
  localparam int unsigned AlignShift  = $clog2(AlignBytes);
  localparam int unsigned HdrIdx      = HeaderBytes / AlignBytes;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [LinkW-1:0] LinkEnd = LinkW'(Depth);

  typedef struct packed {
    logic        op;
    logic [12:0] request_bytes;
    logic [11:0] free_addr;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] data_addr;
  } out_word_t;

  // Memory access bundle from control to store.
  typedef struct packed {
    logic             rd_en;
    logic [IdxW-1:0]  rd_idx;
    logic             sz_we;
    logic [IdxW-1:0]  sz_idx;
    logic [11:0]      sz_data;
    logic             ln_we;
    logic [IdxW-1:0]  ln_idx;
    logic [LinkW-1:0] ln_data;
  } mem_req_t;

  typedef struct packed {
    logic [11:0]      size;
    logic [LinkW-1:0] link;
  } mem_rsp_t;
endpackage

// ===== hw/rtl/ffh_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffh_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface ffh_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ffh_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffh_store
// Block size and next link memories, one read port with registered data.
// ----------------------------------------------------------------------------
module ffh_store import ffh_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output mem_rsp_t rsp_o
);
  logic [11:0]      size_mem [Depth];
  logic [LinkW-1:0] link_mem [Depth];
  logic [11:0]      size_q;
  logic [LinkW-1:0] link_q;

  always_ff @(posedge clk_i) begin
    if (req_i.sz_we) size_mem[req_i.sz_idx] <= req_i.sz_data;
    if (req_i.ln_we) link_mem[req_i.ln_idx] <= req_i.ln_data;
    if (req_i.rd_en) begin
      size_q <= size_mem[req_i.rd_idx];
      link_q <= link_mem[req_i.rd_idx];
    end
  end

  assign rsp_o.size = size_q;
  assign rsp_o.link = link_q;
endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// Sequence: a free goes from idle straight to StOut; an allocate runs StRead
// and StCheck once per free-list entry visited (one read of the store, then
// one compare), then StSeal, with StInit before it when the block is split.
// Throughput: one word at a time; the free-list walk sets the rate.
// Reset: list head at block 0 spanning 4096 bytes; a config write is followed
// by a rebuild of the one-block list in the next cycle. Stores are not cleared.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit free-list allocator with a sequencer around one store.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffh_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  ffh_if.sink   in_ch,
  ffh_if.source out_ch,
  ffh_if.sink   cfg_ch
);
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StInit  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StCheck = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;
  localparam logic [2:0] StSeal  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [12:0]      heap_q, heap_d;
  logic [LinkW-1:0] head_q, head_d;
  logic [LinkW-1:0] prev_q, prev_d;
  logic [LinkW-1:0] cur_q, cur_d;
  logic [IdxW:0]    visits_q, visits_d;
  logic [12:0]      need_q, need_d;
  out_word_t        res_q, res_d;
  logic             init_q, init_d;
  mem_req_t         mreq;
  mem_rsp_t         mrsp;

  ffh_store u_store (.clk_i(clk_i), .req_i(mreq), .rsp_o(mrsp));

  in_word_t w;
  logic [12:0] cfg_v, sat_v;
  logic [13:0] rnd;
  logic [14:0] rest_off, big;
  logic [LinkW-1:0] rest_idx;
  logic [12:0] foff;
  logic [15:0] off_b;

  assign w      = in_ch.data;
  assign cfg_v  = cfg_ch.data;
  assign sat_v  = (cfg_v < 13'(HeapMin)) ? 13'(HeapMin) :
                  (cfg_v > 13'(HeapBytes)) ? 13'(HeapBytes) : cfg_v;
  assign rnd    = (14'(w.request_bytes) + 14'(AlignBytes - 1)) >> AlignShift << AlignShift;
  assign off_b  = 16'(cur_q) << AlignShift;
  assign rest_off = 15'(off_b) + 15'(HeaderBytes) + 15'(need_q);
  assign rest_idx = LinkW'(rest_off >> AlignShift);
  assign big    = 15'(need_q) + 15'(HeaderBytes + AlignBytes);
  assign foff   = 13'(w.free_addr) - 13'(HeaderBytes);

  assign in_ch.ready  = (state_q == StIdle) && !init_q && !cfg_ch.valid;
  assign cfg_ch.ready = (state_q == StIdle) && !init_q;
  assign out_ch.valid = (state_q == StOut);
  assign out_ch.data  = res_q;

  always_comb begin
    state_d = state_q; heap_d = heap_q; head_d = head_q; prev_d = prev_q;
    cur_d = cur_q; visits_d = visits_q; need_d = need_q; res_d = res_q;
    init_d = 1'b0;
    mreq = '0;
    case (state_q)
      StIdle: begin
        if (init_q) begin
          // Rebuild the one-block list at offset zero.
          mreq.sz_we = 1'b1; mreq.sz_idx = '0;
          mreq.sz_data = 12'(heap_q - 13'(HeaderBytes));
          mreq.ln_we = 1'b1; mreq.ln_idx = '0; mreq.ln_data = LinkEnd;
          head_d = '0;
        end else if (cfg_ch.valid) begin
          heap_d = sat_v; init_d = 1'b1;
        end else if (in_ch.valid) begin
          if (w.op == OpAlloc) begin
            need_d = 13'(rnd); prev_d = LinkEnd; cur_d = head_q;
            visits_d = '0; state_d = StRead;
          end else begin
            res_d = '0;
            state_d = StOut;
            if (w.free_addr >= 12'(HeaderBytes) && foff[AlignShift-1:0] == '0 &&
                foff < heap_q) begin
              mreq.ln_we = 1'b1; mreq.ln_idx = IdxW'(foff >> AlignShift);
              mreq.ln_data = head_q;
              head_d = LinkW'(foff >> AlignShift);
              res_d.ok = 1'b1;
            end
          end
        end
      end
      StRead: begin
        if (cur_q[IdxW] || visits_q == (IdxW+1)'(Depth)) begin
          res_d = '0; state_d = StOut;
        end else begin
          mreq.rd_en = 1'b1; mreq.rd_idx = cur_q[IdxW-1:0];
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (need_q <= 13'(mrsp.size)) begin
          if (15'(mrsp.size) > big && !rest_idx[IdxW]) begin
            mreq.sz_we = 1'b1; mreq.sz_idx = rest_idx[IdxW-1:0];
            mreq.sz_data = mrsp.size - 12'(need_q) - 12'(HeaderBytes);
            mreq.ln_we = 1'b1; mreq.ln_idx = rest_idx[IdxW-1:0];
            mreq.ln_data = mrsp.link;
            state_d = StInit;  // second write cycle
          end else begin
            if (prev_q[IdxW]) head_d = mrsp.link;
            else begin
              mreq.ln_we = 1'b1; mreq.ln_idx = prev_q[IdxW-1:0];
              mreq.ln_data = mrsp.link;
            end
            state_d = StSeal;
          end
          res_d.ok = 1'b1;
          res_d.data_addr = 12'(off_b + 16'(HeaderBytes));
        end else begin
          prev_d = cur_q; cur_d = mrsp.link;
          visits_d = visits_q + 1'b1; state_d = StRead;
        end
      end
      StInit: begin
        // Finish the split: shrink the granted block, relink the remainder.
        mreq.sz_we = 1'b1; mreq.sz_idx = cur_q[IdxW-1:0];
        mreq.sz_data = 12'(need_q);
        if (prev_q[IdxW]) head_d = rest_idx;
        else begin
          mreq.ln_we = 1'b1; mreq.ln_idx = prev_q[IdxW-1:0];
          mreq.ln_data = rest_idx;
        end
        state_d = StSeal;
      end
      StSeal: begin
        // Terminate the granted block's link.
        mreq.ln_we = 1'b1; mreq.ln_idx = cur_q[IdxW-1:0];
        mreq.ln_data = LinkEnd;
        state_d = StOut;
      end
      StOut: begin
        if (out_ch.ready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; heap_q <= 13'(HeapBytes); head_q <= '0;
      init_q <= 1'b1; visits_q <= '0;
    end else begin
      state_q <= state_d; heap_q <= heap_d; head_q <= head_d;
      init_q <= init_d; visits_q <= visits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d; cur_q <= cur_d; need_q <= need_d; res_q <= res_d;
  end
endmodule

// ===== hw/rtl/ffh_checker.sv =====
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_defines.svh"
// ----------------------------------------------------------------------------
// ffh_checker
// Port-level checks for the heap allocator.
// ----------------------------------------------------------------------------
module ffh_checker import ffh_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);
  `FFH_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_data))
  `FFH_ASSERT_NOW(a_busy, clk_i, rst_ni, out_valid, !in_ready)
  `FFH_ASSERT_NOW(a_fail0, clk_i, rst_ni, out_valid && !out_data.ok, out_data.data_addr == '0)
  `FFH_ASSERT_NEXT(a_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready)
endmodule

bind first_fit_heap_allocator ffh_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== tb/tb_first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking bench for the first-fit heap allocator: a directed run over
// heap extremes, exact fits, splits and bad frees, then random allocate/free
// traffic under several sender/receiver idle mixes, with heap size rewrites
// between phases. A shadow of the free list predicts every result word.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator;
  import ffh_pkg::*;

  // Shadow allocator plus queue of pending result words.
  class heap_scoreboard;
    int        size_mem [Depth];
    int        link_mem [Depth];
    int        head;
    int        heap;
    out_word_t pending_q[$];
    int        errors;

    function new();
      heap = HeapBytes;
      rebuild();
      errors = 0;
    endfunction

    function void rebuild();
      size_mem[0] = (heap - HeaderBytes) & 16'hFFFF;
      link_mem[0] = Depth;
      head = 0;
    endfunction

    function void set_heap(logic [12:0] v);
      int s;
      s = v;
      if (s < HeapMin) s = HeapMin;
      if (s > HeapBytes) s = HeapBytes;
      heap = s;
      rebuild();
    endfunction

    function void relink(int prv, int tgt);
      if (prv >= Depth) head = tgt;
      else link_mem[prv] = tgt;
    endfunction

    // Predict the result of one accepted word and queue it.
    function out_word_t note_input(in_word_t w);
      out_word_t r;
      int need, prv, cur, visits, sz, off, rest;
      r = '0;
      if (w.op == OpAlloc) begin
        need = ((int'(w.request_bytes) + AlignBytes - 1) / AlignBytes) * AlignBytes;
        prv = Depth;
        cur = head;
        visits = 0;
        while (cur < Depth && visits < Depth) begin
          sz = size_mem[cur];
          if (need <= sz) begin
            off = cur * AlignBytes;
            rest = (off + HeaderBytes + need) / AlignBytes;
            if (sz > need + HeaderBytes + AlignBytes && rest < Depth) begin
              // Split: remainder takes the chosen block's slot in the list.
              size_mem[rest] = sz - need - HeaderBytes;
              link_mem[rest] = link_mem[cur];
              relink(prv, rest);
              size_mem[cur] = need;
            end else begin
              relink(prv, link_mem[cur]);
            end
            link_mem[cur] = Depth;
            r.ok = 1'b1;
            r.data_addr = 12'(off + HeaderBytes);
            break;
          end
          prv = cur;
          cur = link_mem[cur];
          visits++;
        end
      end else if (w.free_addr >= HeaderBytes) begin
        off = int'(w.free_addr) - HeaderBytes;
        if (off % AlignBytes == 0 && off < heap) begin
          link_mem[off / AlignBytes] = head;
          head = off / AlignBytes;
          r.ok = 1'b1;
        end
      end
      pending_q.push_back(r);
      return r;
    endfunction

    function void check(out_word_t got);
      out_word_t exp;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word ok=%0b addr=%0d", got.ok, got.data_addr);
        return;
      end
      exp = pending_q.pop_front();
      if (got.ok !== exp.ok || got.data_addr !== exp.data_addr) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected ok=%0b addr=%0d, got ok=%0b addr=%0d",
                   exp.ok, exp.data_addr, got.ok, got.data_addr);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  always #5 clk_i = ~clk_i;

  ffh_if #(.T(in_word_t))    in_ch  (clk_i);
  ffh_if #(.T(out_word_t))   out_ch (clk_i);
  ffh_if #(.T(logic [12:0])) cfg_ch (clk_i);

  first_fit_heap_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  heap_scoreboard sb = new();

  int send_idle_pct  = 0;   // chance per cycle that the sender holds off
  int recv_stall_pct = 0;   // chance per cycle that the receiver drops ready
  int quiet_cycles   = 0;
  localparam int QuietLimit = 40000;

  logic [11:0] live_q[$];   // data offsets currently handed out
  logic [11:0] seen_q[$];   // every offset ever handed out (store entries written)

  // Receiver: randomly drop ready at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each accepted result word.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check(out_ch.data);
  end

  // Watchdog: abort when no channel moves a word for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_first_fit_heap_allocator: FAIL");
        $finish;
      end
    end
  end

  // Send one word; return at the accepting edge.
  task automatic send_word(in_word_t w);
    out_word_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    r = sb.note_input(w);
    if (w.op == OpAlloc && r.ok) begin
      live_q.push_back(r.data_addr);
      seen_q.push_back(r.data_addr);
    end
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_heap(logic [12:0] v);
    drain();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_heap(v);
    live_q.delete();
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic alloc(int unsigned n);
    in_word_t w;
    w.op = OpAlloc;
    w.request_bytes = 13'(n);
    w.free_addr = 12'($urandom);
    send_word(w);
  endtask

  task automatic release_addr(logic [11:0] a);
    in_word_t w;
    w.op = OpFree;
    w.request_bytes = 13'($urandom);
    w.free_addr = a;
    send_word(w);
  endtask

  // One random word: mostly well-formed allocate/free traffic.
  task automatic random_word();
    int pick, k;
    logic [11:0] a;
    pick = $urandom_range(99);
    if (pick < 48 || (pick < 88 && live_q.size() == 0)) begin
      k = $urandom_range(99);
      if (k < 70) alloc($urandom_range(64));
      else if (k < 95) alloc($urandom_range(400, 65));
      else alloc($urandom_range(4096));
    end else if (pick < 88) begin
      k = $urandom_range(live_q.size() - 1);
      a = live_q[k];
      live_q.delete(k);
      release_addr(a);
    end else if (pick < 97) begin
      // Bad address: below the header or off the alignment grid.
      a = 12'($urandom);
      if (a[2:0] == 3'd0) a = 12'($urandom_range(HeaderBytes - 1));
      release_addr(a);
    end else if (seen_q.size() != 0) begin
      // Double free of a block whose header was written at some point.
      release_addr(seen_q[$urandom_range(seen_q.size() - 1)]);
    end else begin
      alloc($urandom_range(32));
    end
  endtask

  initial begin
    int idle_tab [4];
    int stall_tab[4];
    logic [12:0] heap_tab[5];
    idle_tab  = '{0, 88, 0, 13};
    stall_tab = '{0, 0, 88, 13};
    heap_tab = '{13'd64, 13'd8191, 13'd0, 13'($urandom_range(4096, 64)), 13'd4096};
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: exact fit of the reset heap, zero-byte and oversize requests.
    alloc(4080);
    alloc(0);
    alloc(4096);
    release_addr(12'd16);
    alloc(0);
    alloc(1);
    alloc(8);
    alloc(13'd4096);
    release_addr(12'd0);
    release_addr(12'd15);
    release_addr(12'd17);
    release_addr(12'd4095);
    release_addr(12'd16);
    alloc(24);
    alloc(2000);
    alloc(2000);
    // Smallest heap: one small block, a no-split grab, then nothing fits.
    write_heap(13'd64);
    alloc(40);
    alloc(0);
    release_addr(12'd16);
    release_addr(12'd80);
    alloc(48);
    alloc(24);
    write_heap(13'd4096);
    live_q.delete();

    // Random phases, each under its own idle mix and heap size.
    for (int p = 0; p < 5; p++) begin
      write_heap(heap_tab[p]);
      send_idle_pct  = idle_tab[p % 4];
      recv_stall_pct = stall_tab[p % 4];
      for (int i = 0; i < 350; i++) begin
        if (p == 0 && i == 175) drain();
        random_word();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_first_fit_heap_allocator: PASS");
    end else begin
      $display("tb_first_fit_heap_allocator: FAIL");
    end
    $finish;
  end
endmodule
